// File: rtl/mtg_pkg.sv
`default_nettype none
package mtg_pkg;

  localparam int unsigned STATE_DEPTH  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned ADDR_W       = 10;

  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STATE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] PTR_FULL     = ADDR_W'(STATE_DEPTH);
  localparam logic [ADDR_W-1:0] PTR_UNSEEDED = ADDR_W'(STATE_DEPTH + 1);
  localparam logic [ADDR_W-1:0] FAR_SPLIT    = ADDR_W'(STATE_DEPTH - TWIST_OFFSET);
  localparam logic [ADDR_W-1:0] OFFSET_ADDR  = ADDR_W'(TWIST_OFFSET);

  localparam logic [31:0] TW_MATRIX    = 32'h9908_b0df;
  localparam logic [31:0] TW_UPPER     = 32'h8000_0000;
  localparam logic [31:0] TW_LOWER     = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] LCG_MULT     = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;

  localparam int unsigned CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_DRAW = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = 1;
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = 2;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [ADDR_W-1:0] index;
    logic [31:0]       word;
  } cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] lcg_step(input logic [31:0] s);
    return s * LCG_MULT + 32'd1;
  endfunction

  function automatic logic [31:0] twist_word(input logic        prev_hi,
                                             input logic [31:0] nxt_word,
                                             input logic [31:0] far_word);
    logic [31:0] y;
    y = ({prev_hi, 31'd0} & TW_UPPER) | (nxt_word & TW_LOWER);
    return far_word ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
  endfunction

endpackage
`default_nettype wire

// File: rtl/mtg_front.sv
`default_nettype none
module mtg_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [mtg_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [mtg_pkg::ADDR_W-1:0]  in_load_index,
  input  wire logic [31:0]                 in_load_word,
  input  wire logic [31:0]                 seed_value,
  output logic                             cmd_valid,
  output mtg_pkg::cmd_t                    cmd_head,
  input  wire logic                        cmd_pop
);

  mtg_pkg::cmd_t                    entry_r [mtg_pkg::CMDQ_DEPTH];
  logic [mtg_pkg::CMDQ_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mtg_pkg::CMDQ_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mtg_pkg::CMDQ_AW:0]        count_r, count_nxt;
  logic                             accept;
  logic                             keep;
  logic                             do_pop;
  mtg_pkg::cmd_t                    dec;

  assign full      = (count_r == (mtg_pkg::CMDQ_AW+1)'(mtg_pkg::CMDQ_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd_head  = entry_r[rd_ptr_r];
  assign accept    = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Classify: reseed captures the seed at accept time, bad loads and unused codes drop.
  always_comb begin
    dec.op    = in_cmd;
    dec.index = in_load_index;
    dec.word  = in_load_word;
    keep      = 1'b0;
    unique case (in_cmd)
      mtg_pkg::CMD_DRAW: keep = 1'b1;
      mtg_pkg::CMD_SEED: begin
        keep     = 1'b1;
        dec.word = seed_value;
      end
      mtg_pkg::CMD_LOAD: keep = (in_load_index < mtg_pkg::PTR_FULL);
      default:           keep = 1'b0;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept && keep) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if ((accept && keep) && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!(accept && keep) && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mtg_out_queue.sv
`default_nettype none
module mtg_out_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [31:0]                wr_data,
  input  wire logic                       rd_en,
  output logic [31:0]                     rd_data,
  output logic                            empty,
  output logic [mtg_pkg::OUTQ_AW:0]       level
);

  logic [31:0]                 entry_r [mtg_pkg::OUTQ_DEPTH];
  logic [mtg_pkg::OUTQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [mtg_pkg::OUTQ_AW:0]   count_r, count_nxt;
  logic                        do_pop;

  assign empty   = (count_r == '0);
  assign level   = count_r;
  assign rd_data = entry_r[rd_ptr_r];
  assign do_pop  = rd_en && !empty;

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Writer never overruns: the back end holds a credit per in-flight beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mtg_back.sv
`default_nettype none
module mtg_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cmd_valid,
  input  wire mtg_pkg::cmd_t              cmd_head,
  output logic                            cmd_pop,
  input  wire logic [mtg_pkg::OUTQ_AW:0]  out_level,
  output logic                            res_push,
  output logic [31:0]                     res_word
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEED     = 3'd1;
  localparam logic [2:0] ST_TW_PRIME = 3'd2;
  localparam logic [2:0] ST_TW_RUN   = 3'd3;
  localparam logic [2:0] ST_TW_DRAIN = 3'd4;

  logic [31:0] state_mem [mtg_pkg::STATE_DEPTH];

  logic [2:0]                  state_r, state_nxt;
  logic [mtg_pkg::ADDR_W-1:0]  rp_r, rp_nxt;
  logic [mtg_pkg::ADDR_W-1:0]  k_r, k_nxt;
  logic                        seed_ph_r, seed_ph_nxt;
  logic                        chain_r, chain_nxt;
  logic                        tw_wr_r;
  logic                        draw_vld_r;
  logic [mtg_pkg::ADDR_W-1:0]  tw_k_d_r;
  logic                        prev_hi_r;
  logic [31:0]                 seed_s_r, seed_s_nxt;
  logic [15:0]                 seed_hi_r, seed_hi_nxt;
  logic [31:0]                 rd_a_r, rd_b_r;

  logic                        we;
  logic [mtg_pkg::ADDR_W-1:0]  wa;
  logic [31:0]                 wd;
  logic [mtg_pkg::ADDR_W-1:0]  addr_a, addr_b;
  logic [mtg_pkg::ADDR_W-1:0]  k_next_addr;
  logic                        draw_issue;
  logic [mtg_pkg::OUTQ_AW:0]   committed;
  logic                        space_ok;

  assign k_next_addr = (k_r == mtg_pkg::LAST_ADDR) ? '0 : k_r + 1'b1;
  assign addr_b      = (k_r < mtg_pkg::FAR_SPLIT) ? k_r + mtg_pkg::OFFSET_ADDR
                                                  : k_r - mtg_pkg::FAR_SPLIT;
  assign committed   = out_level + {{mtg_pkg::OUTQ_AW{1'b0}}, draw_vld_r};
  assign space_ok    = (committed < (mtg_pkg::OUTQ_AW+1)'(mtg_pkg::OUTQ_DEPTH));

  assign res_push = draw_vld_r;
  assign res_word = mtg_pkg::temper(rd_a_r);

  always_comb begin
    state_nxt   = state_r;
    rp_nxt      = rp_r;
    k_nxt       = k_r;
    seed_ph_nxt = seed_ph_r;
    chain_nxt   = chain_r;
    seed_s_nxt  = seed_s_r;
    seed_hi_nxt = seed_hi_r;
    cmd_pop     = 1'b0;
    draw_issue  = 1'b0;
    addr_a      = '0;
    // Twist write-back lands in the cycle after its read issue.
    we          = tw_wr_r;
    wa          = tw_k_d_r;
    wd          = mtg_pkg::twist_word(prev_hi_r, rd_a_r, rd_b_r);

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_head.op)
            mtg_pkg::CMD_SEED: begin
              seed_s_nxt  = cmd_head.word;
              seed_ph_nxt = 1'b0;
              k_nxt       = '0;
              chain_nxt   = 1'b0;
              state_nxt   = ST_SEED;
              cmd_pop     = 1'b1;
            end
            mtg_pkg::CMD_LOAD: begin
              we      = 1'b1;
              wa      = cmd_head.index;
              wd      = cmd_head.word;
              rp_nxt  = mtg_pkg::PTR_FULL;
              cmd_pop = 1'b1;
            end
            mtg_pkg::CMD_DRAW: begin
              // Hold the draw at the queue head until the state is ready and the output queue has room.
              if (rp_r == mtg_pkg::PTR_UNSEEDED) begin
                seed_s_nxt  = mtg_pkg::DEFAULT_SEED;
                seed_ph_nxt = 1'b0;
                k_nxt       = '0;
                chain_nxt   = 1'b1;
                state_nxt   = ST_SEED;
              end else if (rp_r == mtg_pkg::PTR_FULL) begin
                state_nxt = ST_TW_PRIME;
              end else if (space_ok) begin
                addr_a     = rp_r;
                draw_issue = 1'b1;
                rp_nxt     = rp_r + 1'b1;
                cmd_pop    = 1'b1;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      ST_SEED: begin
        seed_s_nxt = mtg_pkg::lcg_step(seed_s_r);
        if (!seed_ph_r) begin
          seed_hi_nxt = seed_s_r[31:16];
          seed_ph_nxt = 1'b1;
        end else begin
          we          = 1'b1;
          wa          = k_r;
          wd          = {seed_hi_r, seed_s_r[31:16]};
          seed_ph_nxt = 1'b0;
          k_nxt       = k_next_addr;
          if (k_r == mtg_pkg::LAST_ADDR) begin
            rp_nxt    = mtg_pkg::PTR_FULL;
            state_nxt = chain_r ? ST_TW_PRIME : ST_IDLE;
          end
        end
      end
      ST_TW_PRIME: begin
        addr_a    = '0;
        k_nxt     = '0;
        state_nxt = ST_TW_RUN;
      end
      ST_TW_RUN: begin
        addr_a = k_next_addr;
        k_nxt  = k_next_addr;
        if (k_r == mtg_pkg::LAST_ADDR) begin
          state_nxt = ST_TW_DRAIN;
        end
      end
      ST_TW_DRAIN: begin
        rp_nxt    = '0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rp_r       <= mtg_pkg::PTR_UNSEEDED;
      k_r        <= '0;
      seed_ph_r  <= 1'b0;
      chain_r    <= 1'b0;
      tw_wr_r    <= 1'b0;
      draw_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rp_r       <= rp_nxt;
      k_r        <= k_nxt;
      seed_ph_r  <= seed_ph_nxt;
      chain_r    <= chain_nxt;
      tw_wr_r    <= (state_r == ST_TW_RUN);
      draw_vld_r <= draw_issue;
    end
  end

  always_ff @(posedge clk) begin
    seed_s_r  <= seed_s_nxt;
    seed_hi_r <= seed_hi_nxt;
    tw_k_d_r  <= k_r;
    prev_hi_r <= rd_a_r[31];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      state_mem[wa] <= wd;
    end
    rd_a_r <= state_mem[addr_a];
    rd_b_r <= state_mem[addr_b];
  end

endmodule
`default_nettype wire

// File: rtl/mersenne_twister_generator.sv
// When the state is ready, a draw passes the command queue, the state read register and the output queue.
// Throughput: one draw per cycle while the output queue has room; the first of every 624 draws waits for
// the twist pass (one state word per cycle through the two-read-port memory).
// Reseed holds the back end while it runs two LCG steps per state word; the first draw after
// reset seeds with the default seed first and then runs the twist. A load writes one state word.
// Reset: synchronous, active low; clears the queues and control, state memory is not cleared.
`default_nettype none
module mersenne_twister_generator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [mtg_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [mtg_pkg::ADDR_W-1:0]  in_load_index,
  input  wire logic [31:0]                 in_load_word,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [31:0]                      out_random_word,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [31:0]                 cfg_seed_value
);

  logic [31:0]               seed_value_r;
  logic                      cmd_valid;
  mtg_pkg::cmd_t             cmd_head;
  logic                      cmd_pop;
  logic [mtg_pkg::OUTQ_AW:0] out_level;
  logic                      res_push;
  logic [31:0]               res_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_value_r <= mtg_pkg::DEFAULT_SEED;
    end else if (cfg_valid && cfg_ready) begin
      seed_value_r <= cfg_seed_value;
    end
  end

  mtg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_cmd        (in_cmd),
    .in_load_index (in_load_index),
    .in_load_word  (in_load_word),
    .seed_value    (seed_value_r),
    .cmd_valid     (cmd_valid),
    .cmd_head      (cmd_head),
    .cmd_pop       (cmd_pop)
  );

  mtg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_level (out_level),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  mtg_out_queue u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_word),
    .rd_en   (pop),
    .rd_data (out_random_word),
    .empty   (empty),
    .level   (out_level)
  );

endmodule
`default_nettype wire

// File: rtl/mtg_checker.sv
`default_nettype none
module mtg_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        push,
  input wire logic                        full,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [31:0]                 out_random_word,
  input wire logic                        cfg_ready
);

  // Reset leaves both queues drained.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not drained after reset");

  // A waiting result holds until popped.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_random_word)))
    else $error("waiting result changed or vanished");

  // Full rises only after a push.
  a_full_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // Empty rises only when the last result is popped.
  a_empty_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(empty) |-> $past(pop))
    else $error("result lost without a pop");

  a_cfg_always_ready: assert property (@(posedge clk)
    rst_n |-> cfg_ready)
    else $error("config channel stalled");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);
`default_nettype wire
